FILE: hdl/rk4_pkg.sv
// ----------------------------------------------------------------------------
// rk4_pkg: shared types, constants and helpers
// Fixed-point formats, register indexes, saturation and the radix-16
// divide-by-three digit step used by the RK4 stepper.
// ----------------------------------------------------------------------------
package rk4_pkg;

    // number formats
    localparam int FRAC_BITS = 16;
    localparam int WORD_W    = 32;
    localparam int STEP_W    = 31;
    localparam int COUNT_W   = 16;
    localparam int PROD_W    = 2 * WORD_W;

    // weighted slope sum k1 + 2*k2 + 2*k3 + k4 + 3 stays inside this width
    localparam int SUM_W     = WORD_W + 3;

    // divide-by-three datapath: radix-16 digits, several digits per cycle
    localparam int DIG_W        = 4;
    localparam int DIG_PER_CYC  = 3;
    localparam int DIV_CHUNK_W  = DIG_W * DIG_PER_CYC;
    localparam int DIV_W        = ((WORD_W + 2 + DIV_CHUNK_W - 1) / DIV_CHUNK_W)
                                  * DIV_CHUNK_W;
    localparam int DIV_CYCLES   = DIV_W / DIV_CHUNK_W;
    localparam int DIV_CNT_W    = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

    // reciprocal of three for a 6-bit partial dividend
    localparam int RECIP3       = 43;
    localparam int RECIP3_SH    = 7;
    localparam int RECIP3_PW    = 11;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_X     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_BOUND = 2'd3;

    // register reset values
    localparam logic signed [WORD_W-1:0] START_X_RST     = 32'sd0;
    localparam logic signed [WORD_W-1:0] START_Y_RST     = 32'sd65536;
    localparam logic        [STEP_W-1:0] STEP_SIZE_RST   = 31'd6554;
    localparam logic signed [WORD_W-1:0] UPPER_BOUND_RST = 32'sd65536;

    // saturated word with its overflow flag
    typedef struct packed {
        logic                     ovf;
        logic signed [WORD_W-1:0] value;
    } sat_word_t;

    // sign-extend a word to product width
    function automatic logic signed [PROD_W-1:0] widen(input logic signed [WORD_W-1:0] v);
        return {{(PROD_W-WORD_W){v[WORD_W-1]}}, v};
    endfunction

    // clamp a wide signed value to one word
    function automatic sat_word_t sat_word(input logic signed [PROD_W-1:0] v);
        logic [PROD_W-WORD_W:0] upper;
        sat_word_t              res;
        upper = v[PROD_W-1:WORD_W-1];
        if ((&upper) || !(|upper)) begin
            res.ovf   = 1'b0;
            res.value = v[WORD_W-1:0];
        end else if (v[PROD_W-1]) begin
            res.ovf   = 1'b1;
            res.value = {1'b1, {(WORD_W-1){1'b0}}};
        end else begin
            res.ovf   = 1'b1;
            res.value = {1'b0, {(WORD_W-1){1'b1}}};
        end
        return res;
    endfunction

    // one radix-16 digit of a divide by three: returns {quotient digit, remainder}
    function automatic logic [DIG_W+1:0] div3_digit(input logic [1:0]       rem_in,
                                                    input logic [DIG_W-1:0] digit);
        logic [DIG_W+1:0]     num;
        logic [RECIP3_PW-1:0] prod;
        logic [DIG_W-1:0]     quo;
        logic [DIG_W+1:0]     back;
        num  = {rem_in, digit};
        prod = RECIP3_PW'(num) * RECIP3_PW'(RECIP3);
        quo  = prod[RECIP3_SH +: DIG_W];
        back = num - (DIG_W+2)'(quo) * (DIG_W+2)'(3);
        return {quo, back[1:0]};
    endfunction

endpackage

FILE: hdl/rk4_mul.sv
// ----------------------------------------------------------------------------
// rk4_mul: shared fixed-point multiplier
// Registered operands, registered 64-bit product, then round half up,
// floor shift by the fraction width and saturate to one word in a result register.
// ----------------------------------------------------------------------------
module rk4_mul (
    input  logic                             aclk,
    input  logic                             load,
    input  logic signed [rk4_pkg::WORD_W-1:0] op_a,
    input  logic signed [rk4_pkg::WORD_W-1:0] op_b,
    output rk4_pkg::sat_word_t               result
);

    localparam logic signed [rk4_pkg::PROD_W-1:0] RND_BIAS =
        rk4_pkg::PROD_W'(1) <<< (rk4_pkg::FRAC_BITS - 1);

    logic signed [rk4_pkg::WORD_W-1:0] a_reg;
    logic signed [rk4_pkg::WORD_W-1:0] b_reg;
    logic signed [rk4_pkg::PROD_W-1:0] prod_reg;
    logic signed [rk4_pkg::PROD_W-1:0] rounded;
    logic signed [rk4_pkg::PROD_W-1:0] shifted;
    rk4_pkg::sat_word_t                res_reg;
    rk4_pkg::sat_word_t                res_next;

    // round half up, floor shift, clamp
    always_comb begin
        rounded  = prod_reg + RND_BIAS;
        shifted  = rounded >>> rk4_pkg::FRAC_BITS;
        res_next = rk4_pkg::sat_word(shifted);
    end

    // operand, product and result stages
    always_ff @(posedge aclk) begin
        if (load) begin
            a_reg <= op_a;
            b_reg <= op_b;
        end
        prod_reg <= a_reg * b_reg;
        res_reg  <= res_next;
    end

    assign result = res_reg;

endmodule

FILE: hdl/rk4_step_xy_ode.sv
// ----------------------------------------------------------------------------
// rk4_step_xy_ode: fourth-order Runge-Kutta stepper for dy/dx = x*y
// Signed Q16.16 datapath around one shared multiplier. A restart beat loads
// the start point; an advance beat computes k1..k4 and emits the next point.
//
//   channel  direction  handshake          payload
//   s_       in         s_valid/s_ready    s_restart
//   m_       out        m_valid/m_ready    point_number, x, y, last, overflowed
//   cfg_     in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// Advance beat: eight dependent multiplications through the operand, product
// and result registers of the shared multiplier, a divider set-up state, the
// divide-by-six (three radix-16 digits per cycle), an update state and the
// output state, which registers the result and returns to idle for the next
// beat. Restart beat: loads the start point and goes straight to the output state.
// s_ready is high only while idle; a finished result waits in the output
// register while m_ready is low, holding the sequencer until it is taken.
// Reset is synchronous, active low; no clearing pass. cfg_ready is always high.
// ----------------------------------------------------------------------------
module rk4_step_xy_ode (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_restart,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic        [rk4_pkg::COUNT_W-1:0]  m_point_number,
    output logic signed [rk4_pkg::WORD_W-1:0]   m_x_value,
    output logic signed [rk4_pkg::WORD_W-1:0]   m_y_value,
    output logic                                m_last_point,
    output logic                                m_overflowed,
    // configuration channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic        [rk4_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        [rk4_pkg::WORD_W-1:0]   cfg_data
);

    localparam int SEQ_W = 3;
    localparam logic [SEQ_W-1:0] SEQ_K1 = 3'd1;
    localparam logic [SEQ_W-1:0] SEQ_K2 = 3'd3;
    localparam logic [SEQ_W-1:0] SEQ_K3 = 3'd5;
    localparam logic [SEQ_W-1:0] SEQ_K4 = 3'd7;

    localparam logic signed [rk4_pkg::SUM_W-1:0] SUM_BIAS = rk4_pkg::SUM_W'(3);
    localparam logic [rk4_pkg::DIV_W-1:0] DIV_OFFSET =
        rk4_pkg::DIV_W'(3) << rk4_pkg::WORD_W;
    localparam logic signed [rk4_pkg::PROD_W-1:0] QUO_OFFSET =
        rk4_pkg::PROD_W'(1) <<< rk4_pkg::WORD_W;
    localparam logic [rk4_pkg::DIV_CNT_W-1:0] DIV_LAST =
        rk4_pkg::DIV_CNT_W'(rk4_pkg::DIV_CYCLES - 1);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_MUL   = 8'b0000_0010,
        ST_RND   = 8'b0000_0100,
        ST_NEXT  = 8'b0000_1000,
        ST_DPREP = 8'b0001_0000,
        ST_DIV   = 8'b0010_0000,
        ST_UPD   = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    // configuration registers
    logic signed [rk4_pkg::WORD_W-1:0]  start_x_reg;
    logic signed [rk4_pkg::WORD_W-1:0]  start_y_reg;
    logic        [rk4_pkg::STEP_W-1:0]  step_size_reg;
    logic signed [rk4_pkg::WORD_W-1:0]  upper_bound_reg;

    // control and state
    state_t                             state_reg, state_next;
    logic [SEQ_W-1:0]                   seq_cnt_reg, seq_cnt_next;
    logic [rk4_pkg::DIV_CNT_W-1:0]      div_cnt_reg, div_cnt_next;
    logic                               ovf_reg, ovf_next;
    logic signed [rk4_pkg::WORD_W-1:0]  cur_x_reg, cur_x_next;
    logic signed [rk4_pkg::WORD_W-1:0]  cur_y_reg, cur_y_next;
    logic [rk4_pkg::COUNT_W-1:0]        count_reg, count_next;
    logic                               m_valid_reg, m_valid_next;

    // datapath registers
    logic signed [rk4_pkg::WORD_W-1:0]  xm_reg, xm_next;
    logic signed [rk4_pkg::WORD_W-1:0]  xe_reg, xe_next;
    logic signed [rk4_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic [rk4_pkg::DIV_W-1:0]          div_reg, div_next;
    logic [1:0]                         rem_reg, rem_next;

    // output registers
    logic                               out_load;
    logic [rk4_pkg::COUNT_W-1:0]        out_count_reg;
    logic signed [rk4_pkg::WORD_W-1:0]  out_x_reg;
    logic signed [rk4_pkg::WORD_W-1:0]  out_y_reg;
    logic                               out_last_reg;
    logic                               out_ovf_reg;

    // multiplier interface
    logic                               mul_load;
    logic signed [rk4_pkg::WORD_W-1:0]  mul_a;
    logic signed [rk4_pkg::WORD_W-1:0]  mul_b;
    rk4_pkg::sat_word_t                 mul_res;

    // combinational datapath
    logic signed [rk4_pkg::WORD_W-1:0]  h_word;
    logic signed [rk4_pkg::WORD_W-1:0]  half_h;
    rk4_pkg::sat_word_t                 xm_sat;
    rk4_pkg::sat_word_t                 xe_sat;
    logic signed [rk4_pkg::WORD_W-1:0]  k_val;
    logic signed [rk4_pkg::WORD_W-1:0]  y_addend;
    rk4_pkg::sat_word_t                 y_op;
    logic signed [rk4_pkg::SUM_W-1:0]   k_ext;
    logic signed [rk4_pkg::SUM_W-1:0]   k_weighted;
    logic signed [rk4_pkg::SUM_W-1:0]   sum_half;
    logic [rk4_pkg::DIV_W-1:0]          div_start;
    logic [rk4_pkg::DIV_W-1:0]          div_step;
    logic [1:0]                         rem_step;
    logic signed [rk4_pkg::PROD_W-1:0]  quo_delta;
    rk4_pkg::sat_word_t                 y_new;
    logic                               last_flag;

    rk4_mul u_mul (
        .aclk   (aclk),
        .load   (mul_load),
        .op_a   (mul_a),
        .op_b   (mul_b),
        .result (mul_res)
    );

    // midpoint and end abscissas
    always_comb begin
        h_word = {1'b0, step_size_reg};
        half_h = {2'b00, step_size_reg[rk4_pkg::STEP_W-1:1]};
        xm_sat = rk4_pkg::sat_word(rk4_pkg::widen(cur_x_reg) + rk4_pkg::widen(half_h));
        xe_sat = rk4_pkg::sat_word(rk4_pkg::widen(cur_x_reg) + rk4_pkg::widen(h_word));
    end

    // slope result: next y operand and weighted accumulation
    always_comb begin
        k_val      = mul_res.value;
        y_addend   = (seq_cnt_reg == SEQ_K3) ? k_val : (k_val >>> 1);
        y_op       = rk4_pkg::sat_word(rk4_pkg::widen(cur_y_reg) + rk4_pkg::widen(y_addend));
        k_ext      = {{(rk4_pkg::SUM_W-rk4_pkg::WORD_W){k_val[rk4_pkg::WORD_W-1]}}, k_val};
        k_weighted = (seq_cnt_reg == SEQ_K1 || seq_cnt_reg == SEQ_K4) ? k_ext
                                                                      : (k_ext <<< 1);
    end

    // divide by six: halve, then offset into positive range for divide by three
    always_comb begin
        sum_half  = sum_reg >>> 1;
        div_start = {{(rk4_pkg::DIV_W-rk4_pkg::SUM_W){sum_half[rk4_pkg::SUM_W-1]}}, sum_half}
                    + DIV_OFFSET;
    end

    // several radix-16 digits of the divide by three per cycle
    always_comb begin
        logic [1:0]                        rem;
        logic [rk4_pkg::DIG_W+1:0]         dq;
        logic [rk4_pkg::DIV_CHUNK_W-1:0]   qbits;
        rem   = rem_reg;
        qbits = '0;
        for (int i = 0; i < rk4_pkg::DIG_PER_CYC; i++) begin
            dq  = rk4_pkg::div3_digit(rem,
                      div_reg[rk4_pkg::DIV_W-1-rk4_pkg::DIG_W*i -: rk4_pkg::DIG_W]);
            rem = dq[1:0];
            qbits[rk4_pkg::DIV_CHUNK_W-1-rk4_pkg::DIG_W*i -: rk4_pkg::DIG_W] =
                dq[rk4_pkg::DIG_W+1:2];
        end
        div_step = {div_reg[rk4_pkg::DIV_W-rk4_pkg::DIV_CHUNK_W-1:0], qbits};
        rem_step = rem;
    end

    // new y from the quotient, minus the offset's share
    always_comb begin
        quo_delta = {{(rk4_pkg::PROD_W-rk4_pkg::DIV_W){1'b0}}, div_reg} - QUO_OFFSET;
        y_new     = rk4_pkg::sat_word(rk4_pkg::widen(cur_y_reg) + quo_delta);
        last_flag = (cur_x_reg > upper_bound_reg);
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        seq_cnt_next = seq_cnt_reg;
        div_cnt_next = div_cnt_reg;
        ovf_next     = ovf_reg;
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        count_next   = count_reg;
        xm_next      = xm_reg;
        xe_next      = xe_reg;
        sum_next     = sum_reg;
        div_next     = div_reg;
        rem_next     = rem_reg;
        mul_load     = 1'b0;
        mul_a        = cur_x_reg;
        mul_b        = cur_y_reg;
        out_load     = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    ovf_next = 1'b0;
                    if (s_restart) begin
                        cur_x_next = start_x_reg;
                        cur_y_next = start_y_reg;
                        count_next = rk4_pkg::COUNT_W'(1);
                        state_next = ST_DONE;
                    end else begin
                        xm_next      = xm_sat.value;
                        xe_next      = xe_sat.value;
                        ovf_next     = xm_sat.ovf | xe_sat.ovf;
                        sum_next     = SUM_BIAS;
                        seq_cnt_next = '0;
                        mul_load     = 1'b1;
                        state_next   = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                state_next = ST_RND;
            end
            ST_RND: begin
                state_next = ST_NEXT;
            end
            ST_NEXT: begin
                ovf_next = ovf_reg | mul_res.ovf;
                if (!seq_cnt_reg[0]) begin
                    // inner product done: scale by h
                    mul_load     = 1'b1;
                    mul_a        = h_word;
                    mul_b        = k_val;
                    seq_cnt_next = seq_cnt_reg + SEQ_W'(1);
                    state_next   = ST_MUL;
                end else begin
                    // slope done: accumulate, set up the next stage
                    sum_next = sum_reg + k_weighted;
                    if (seq_cnt_reg == SEQ_K4) begin
                        state_next = ST_DPREP;
                    end else begin
                        mul_load     = 1'b1;
                        mul_a        = (seq_cnt_reg == SEQ_K3) ? xe_reg : xm_reg;
                        mul_b        = y_op.value;
                        ovf_next     = ovf_reg | mul_res.ovf | y_op.ovf;
                        seq_cnt_next = seq_cnt_reg + SEQ_W'(1);
                        state_next   = ST_MUL;
                    end
                end
            end
            ST_DPREP: begin
                div_next     = div_start;
                rem_next     = 2'b00;
                div_cnt_next = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                div_next     = div_step;
                rem_next     = rem_step;
                div_cnt_next = div_cnt_reg + rk4_pkg::DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_LAST) begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                cur_y_next = y_new.value;
                cur_x_next = xe_reg;
                ovf_next   = ovf_reg | y_new.ovf;
                count_next = (count_reg != '1) ? count_reg + rk4_pkg::COUNT_W'(1) : count_reg;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            seq_cnt_reg <= '0;
            div_cnt_reg <= '0;
            ovf_reg     <= 1'b0;
            cur_x_reg   <= '0;
            cur_y_reg   <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            seq_cnt_reg <= seq_cnt_next;
            div_cnt_reg <= div_cnt_next;
            ovf_reg     <= ovf_next;
            cur_x_reg   <= cur_x_next;
            cur_y_reg   <= cur_y_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_x_reg     <= rk4_pkg::START_X_RST;
            start_y_reg     <= rk4_pkg::START_Y_RST;
            step_size_reg   <= rk4_pkg::STEP_SIZE_RST;
            upper_bound_reg <= rk4_pkg::UPPER_BOUND_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                rk4_pkg::CFG_START_X:     start_x_reg     <= cfg_data;
                rk4_pkg::CFG_START_Y:     start_y_reg     <= cfg_data;
                rk4_pkg::CFG_STEP_SIZE:   step_size_reg   <= cfg_data[rk4_pkg::STEP_W-1:0];
                rk4_pkg::CFG_UPPER_BOUND: upper_bound_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // datapath and output payload
    always_ff @(posedge aclk) begin
        xm_reg  <= xm_next;
        xe_reg  <= xe_next;
        sum_reg <= sum_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
        if (out_load) begin
            out_count_reg <= count_reg;
            out_x_reg     <= cur_x_reg;
            out_y_reg     <= cur_y_reg;
            out_last_reg  <= last_flag;
            out_ovf_reg   <= ovf_reg;
        end
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign cfg_ready      = 1'b1;
    assign m_valid        = m_valid_reg;
    assign m_point_number = out_count_reg;
    assign m_x_value      = out_x_reg;
    assign m_y_value      = out_y_reg;
    assign m_last_point   = out_last_reg;
    assign m_overflowed   = out_ovf_reg;

    // an advance beat starts the multiply chain
    a_adv_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_restart) |=> (state_reg == ST_MUL))
        else $error("advance beat did not start the multiply chain");

    // a restart beat goes straight to the result with point one and no overflow
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_restart) |=>
            (state_reg == ST_DONE && count_reg == rk4_pkg::COUNT_W'(1) && !ovf_reg))
        else $error("restart beat mishandled");

    // k4 closes the multiply chain and hands off to the divider
    a_k4_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_NEXT && seq_cnt_reg == SEQ_K4) |=> (state_reg == ST_DPREP))
        else $error("sequencer did not leave the multiply chain after k4");

    // a completed step always leaves a nonzero point count
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPD) |=> (count_reg != '0 && state_reg == ST_DONE))
        else $error("point count not advanced by step update");

endmodule

FILE: tb/sv/rk4_point_checker.sv
// ----------------------------------------------------------------------------
// rk4_point_checker: result checker for the RK4 stepper
// Watches the configuration, input and result channels. Keeps its own copy of
// the registers and of the current point, works out the expected point for
// every accepted input beat and compares each accepted result beat with the
// oldest expected point, field by field.
// ----------------------------------------------------------------------------
module rk4_point_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input channel
    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  logic                                 s_restart,
    // result channel
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  logic        [rk4_pkg::COUNT_W-1:0]   m_point_number,
    input  logic signed [rk4_pkg::WORD_W-1:0]    m_x_value,
    input  logic signed [rk4_pkg::WORD_W-1:0]    m_y_value,
    input  logic                                 m_last_point,
    input  logic                                 m_overflowed,
    // configuration channel
    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic        [rk4_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        [rk4_pkg::WORD_W-1:0]    cfg_data,
    // status for the testbench top
    output int                                   mismatch_count,
    output int                                   points_checked,
    output int                                   points_pending
);

    localparam int     REPORT_LIMIT = 10;
    localparam longint WORD_MAX     = 64'sd2147483647;
    localparam longint WORD_MIN     = -64'sd2147483648;

    typedef struct packed {
        logic        [rk4_pkg::COUNT_W-1:0] number;
        logic signed [rk4_pkg::WORD_W-1:0]  x;
        logic signed [rk4_pkg::WORD_W-1:0]  y;
        logic                               last;
        logic                               ovf;
    } point_t;

    // register copies
    logic signed [rk4_pkg::WORD_W-1:0]  start_x_reg = rk4_pkg::START_X_RST;
    logic signed [rk4_pkg::WORD_W-1:0]  start_y_reg = rk4_pkg::START_Y_RST;
    logic        [rk4_pkg::STEP_W-1:0]  step_reg    = rk4_pkg::STEP_SIZE_RST;
    logic signed [rk4_pkg::WORD_W-1:0]  bound_reg   = rk4_pkg::UPPER_BOUND_RST;

    // current point of the integration
    logic signed [rk4_pkg::WORD_W-1:0]  pos_x     = '0;
    logic signed [rk4_pkg::WORD_W-1:0]  pos_y     = '0;
    logic        [rk4_pkg::COUNT_W-1:0] pos_count = '0;

    bit     ovf_seen;
    int     errors = 0;
    point_t expected_points[$];

    // clamp to one signed word, noting saturation
    function automatic longint clamp_word(input longint v);
        if (v > WORD_MAX) begin
            ovf_seen = 1'b1;
            return WORD_MAX;
        end
        if (v < WORD_MIN) begin
            ovf_seen = 1'b1;
            return WORD_MIN;
        end
        return v;
    endfunction

    // fixed-point product, round half up, saturated
    function automatic longint fx_product(input longint a, input longint b);
        longint p;
        p = a * b + (64'sd1 <<< (rk4_pkg::FRAC_BITS - 1));
        return clamp_word(p >>> rk4_pkg::FRAC_BITS);
    endfunction

    // floor division by six
    function automatic longint floor_div6(input longint n);
        if (n >= 0)
            return n / 6;
        return -((-n + 5) / 6);
    endfunction

    // next emitted point; advances the point copy
    function automatic point_t rk4_next_point(input logic restart);
        longint h, x, y, xm, xe, k1, k2, k3, k4, weighted;
        point_t pt;
        ovf_seen = 1'b0;
        if (restart) begin
            pos_x     = start_x_reg;
            pos_y     = start_y_reg;
            pos_count = rk4_pkg::COUNT_W'(1);
        end else begin
            h  = step_reg;
            x  = pos_x;
            y  = pos_y;
            xm = clamp_word(x + (h >>> 1));
            xe = clamp_word(x + h);
            k1 = fx_product(h, fx_product(x, y));
            k2 = fx_product(h, fx_product(xm, clamp_word(y + (k1 >>> 1))));
            k3 = fx_product(h, fx_product(xm, clamp_word(y + (k2 >>> 1))));
            k4 = fx_product(h, fx_product(xe, clamp_word(y + k3)));
            weighted = k1 + 2 * k2 + 2 * k3 + k4;
            y  = clamp_word(y + floor_div6(weighted + 3));
            pos_x = xe[rk4_pkg::WORD_W-1:0];
            pos_y = y[rk4_pkg::WORD_W-1:0];
            if (pos_count != '1)
                pos_count = pos_count + 1'b1;
        end
        pt.number = pos_count;
        pt.x      = pos_x;
        pt.y      = pos_y;
        pt.last   = (pos_x > bound_reg);
        pt.ovf    = ovf_seen;
        return pt;
    endfunction

    // follow the three channels beat by beat
    always @(posedge aclk) begin : watch_beats
        point_t want;
        point_t seen;
        if (!aresetn) begin
            start_x_reg = rk4_pkg::START_X_RST;
            start_y_reg = rk4_pkg::START_Y_RST;
            step_reg    = rk4_pkg::STEP_SIZE_RST;
            bound_reg   = rk4_pkg::UPPER_BOUND_RST;
            pos_x       = '0;
            pos_y       = '0;
            pos_count   = '0;
            expected_points.delete();
        end else begin
            // register write beat
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    rk4_pkg::CFG_START_X:     start_x_reg = cfg_data;
                    rk4_pkg::CFG_START_Y:     start_y_reg = cfg_data;
                    rk4_pkg::CFG_STEP_SIZE:   step_reg    = cfg_data[rk4_pkg::STEP_W-1:0];
                    rk4_pkg::CFG_UPPER_BOUND: bound_reg   = cfg_data;
                    default: ;
                endcase
            end
            // input beat
            if (s_valid && s_ready)
                expected_points.push_back(rk4_next_point(s_restart));
            // result beat
            if (m_valid && m_ready) begin
                seen = {m_point_number, m_x_value, m_y_value, m_last_point, m_overflowed};
                if (expected_points.size() == 0) begin
                    if (errors < REPORT_LIMIT)
                        $display("unexpected result beat: n=%0d x=%0d y=%0d last=%0b ovf=%0b",
                                 seen.number, seen.x, seen.y, seen.last, seen.ovf);
                    errors++;
                end else begin
                    want = expected_points.pop_front();
                    if (seen.number !== want.number || seen.x !== want.x ||
                        seen.y !== want.y || seen.last !== want.last ||
                        seen.ovf !== want.ovf) begin
                        if (errors < REPORT_LIMIT)
                            $display({"point mismatch: expected n=%0d x=%0d y=%0d last=%0b ",
                                      "ovf=%0b, got n=%0d x=%0d y=%0d last=%0b ovf=%0b"},
                                     want.number, want.x, want.y, want.last, want.ovf,
                                     seen.number, seen.x, seen.y, seen.last, seen.ovf);
                        errors++;
                    end
                end
                points_checked <= points_checked + 1;
            end
        end
        mismatch_count <= errors;
        points_pending <= expected_points.size();
    end

endmodule

FILE: tb/sv/rk4_step_xy_ode_tb.sv
// ----------------------------------------------------------------------------
// rk4_step_xy_ode_tb: testbench top for the RK4 stepper
// Drives register writes and restart/advance beats with random idling on
// both channels, starting with a directed set of corner points and then
// random trajectories under many register settings. The point checker
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module rk4_step_xy_ode_tb;

    localparam int HALF_PERIOD  = 6;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int ITEM_TARGET  = 1500;

    logic                                aclk      = 1'b0;
    logic                                aresetn   = 1'b0;
    logic                                s_valid   = 1'b0;
    logic                                s_ready;
    logic                                s_restart = 1'b0;
    logic                                m_valid;
    logic                                m_ready   = 1'b0;
    logic        [rk4_pkg::COUNT_W-1:0]  m_point_number;
    logic signed [rk4_pkg::WORD_W-1:0]   m_x_value;
    logic signed [rk4_pkg::WORD_W-1:0]   m_y_value;
    logic                                m_last_point;
    logic                                m_overflowed;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic        [rk4_pkg::CFG_IDX_W-1:0] cfg_index = rk4_pkg::CFG_START_X;
    logic        [rk4_pkg::WORD_W-1:0]   cfg_data  = '0;

    int idle_pct     = 24;
    int beats_sent   = 0;
    int stall_cycles = 0;
    int mismatch_count;
    int points_checked;
    int points_pending;

    always #HALF_PERIOD aclk = ~aclk;

    rk4_step_xy_ode dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_restart      (s_restart),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_point_number (m_point_number),
        .m_x_value      (m_x_value),
        .m_y_value      (m_y_value),
        .m_last_point   (m_last_point),
        .m_overflowed   (m_overflowed),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    rk4_point_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_restart      (s_restart),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_point_number (m_point_number),
        .m_x_value      (m_x_value),
        .m_y_value      (m_y_value),
        .m_last_point   (m_last_point),
        .m_overflowed   (m_overflowed),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .points_checked (points_checked),
        .points_pending (points_pending)
    );

    // result side back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= idle_pct);
    end

    // watchdog on cycles without any beat
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // one input beat; valid stays up unless the next beat opens with a gap
    task automatic send_beat(input logic restart);
        if ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < idle_pct)
                @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_restart <= restart;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        beats_sent++;
    endtask

    // one register write beat; valid left up for a following write
    task automatic write_reg(input logic [rk4_pkg::CFG_IDX_W-1:0] index,
                             input logic [rk4_pkg::WORD_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
    endtask

    task automatic load_config(input logic [rk4_pkg::WORD_W-1:0] sx,
                               input logic [rk4_pkg::WORD_W-1:0] sy,
                               input logic [rk4_pkg::WORD_W-1:0] h,
                               input logic [rk4_pkg::WORD_W-1:0] ub);
        write_reg(rk4_pkg::CFG_START_X, sx);
        write_reg(rk4_pkg::CFG_START_Y, sy);
        write_reg(rk4_pkg::CFG_STEP_SIZE, h);
        write_reg(rk4_pkg::CFG_UPPER_BOUND, ub);
        cfg_valid <= 1'b0;
    endtask

    // stop sending and wait for every result to come back
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (points_checked != beats_sent)
            @(posedge aclk);
    endtask

    // mostly sane start points and steps, sometimes anything at all
    task automatic pick_config();
        int sx, sy, h, ub;
        if ($urandom_range(9) < 2) begin
            sx = $urandom;
            sy = $urandom;
            h  = $urandom;
            ub = $urandom;
        end else begin
            sx = int'($urandom_range(524288)) - 262144;
            sy = int'($urandom_range(1048576)) - 524288;
            h  = ($urandom_range(3) == 0) ? int'($urandom_range(64))
                                          : int'($urandom_range(1, 32768));
            ub = sx + h * int'($urandom_range(40));
        end
        load_config(sx, sy, h, ub);
    endtask

    // a run of advance beats, usually opened by a restart, rare restarts inside
    task automatic run_trajectory(input int count, input bit lead_restart);
        for (int i = 0; i < count; i++)
            send_beat((i == 0 && lead_restart) || ($urandom_range(99) < 4));
    endtask

    initial begin
        int phase;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // advance from the reset point, then a default run past the bound
        send_beat(1'b0);
        send_beat(1'b1);
        repeat (11) send_beat(1'b0);
        wait_idle();

        // near-largest start point, largest step, lowest bound: saturation everywhere
        load_config(32'h7FFF_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_beat(1'b1);
        send_beat(1'b0);
        send_beat(1'b0);
        wait_idle();

        // most negative start point, smallest nonzero step, highest bound
        load_config(32'h8000_0000, 32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF);
        send_beat(1'b1);
        send_beat(1'b0);
        send_beat(1'b0);
        wait_idle();

        // zero step with x sitting on the bound
        load_config(32'h0001_8000, 32'hFFFE_0000, 32'h0000_0000, 32'h0001_8000);
        send_beat(1'b1);
        send_beat(1'b0);
        send_beat(1'b0);

        // random trajectories, a few phases without any idling
        phase = 0;
        while (beats_sent < ITEM_TARGET) begin
            wait_idle();
            idle_pct = (phase >= 4 && phase < 8) ? 0 : 24;
            pick_config();
            run_trajectory($urandom_range(20, 80), $urandom_range(6) != 0);
            phase++;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && points_pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
